/* rtl/lxd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxd_pkg: shared types and constants of the 8-neighbour extrema detector
// Holds the configuration register indexes, the field widths of a result
// beat, the class codes and the per-result metadata record.
// ----------------------------------------------------------------------------
package lxd_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths of configuration and result fields.
    localparam int CFG_DATA_BITS   = 16;
    localparam int ROW_BITS        = 16;
    localparam int COLUMN_CFG_BITS = 11;
    localparam int COLUMN_BITS     = 10;
    localparam int COUNT_BITS      = 26;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Number of results one input beat can cause.
    localparam int RESULT_SLOTS = 4;

    // Configuration register indexes.
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // Classification codes.
    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_MAX  = 2'd1,
        CLASS_MIN  = 2'd2
    } extremum_class_t;

    // Everything about one pending result except the sample value.
    typedef struct packed {
        logic [ROW_BITS-1:0]    row;
        logic [COLUMN_BITS-1:0] column;
        extremum_class_t        ext_class;
        logic                   last;
    } result_meta_t;

endpackage

/* rtl/lxd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxd_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address and holds until the next read.
// ----------------------------------------------------------------------------
module lxd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/lxd_classify.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxd_classify: strict local extremum test of one element
// Compares the center sample with up to eight neighbors; only neighbors
// whose use bit is set take part.
// ----------------------------------------------------------------------------
module lxd_classify #(
    parameter int SAMPLE_BITS = lxd_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]      center,
    input  logic [7:0][SAMPLE_BITS-1:0] neighbours,
    input  logic [7:0]                  nb_used,
    output lxd_pkg::extremum_class_t    ext_class
);

    logic is_max;
    logic is_min;

    // Signed compare against every neighbor in use.
    always_comb
    begin
        is_max = 1'b1;
        is_min = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (nb_used[i])
            begin
                if (!($signed(center) > $signed(neighbours[i])))
                begin
                    is_max = 1'b0;
                end
                if (!($signed(center) < $signed(neighbours[i])))
                begin
                    is_min = 1'b0;
                end
            end
        end
    end

    // A maximum wins over a minimum (both cannot hold with a neighbor).
    always_comb
    begin
        priority if (is_max)
        begin
            ext_class = lxd_pkg::CLASS_MAX;
        end
        else if (is_min)
        begin
            ext_class = lxd_pkg::CLASS_MIN;
        end
        else
        begin
            ext_class = lxd_pkg::CLASS_NONE;
        end
    end

endmodule

/* rtl/lxd_result_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lxd_result_queue: result slots, output register and running counts
// Takes up to four results at once, hands them out in slot order, one beat
// per cycle unless stalled, and attaches per-frame maximum and minimum counts.
// ----------------------------------------------------------------------------
module lxd_result_queue #(
    parameter int SAMPLE_BITS = lxd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      restart,
    input  logic                                      load,
    input  logic [lxd_pkg::RESULT_SLOTS-1:0]          load_mask,
    input  lxd_pkg::result_meta_t                     load_meta [lxd_pkg::RESULT_SLOTS],
    input  logic [lxd_pkg::RESULT_SLOTS-1:0][SAMPLE_BITS-1:0] load_value,
    output logic                                      free,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [lxd_pkg::ROW_BITS-1:0]              row_index,
    output logic [lxd_pkg::COLUMN_BITS-1:0]           column_index,
    output logic [SAMPLE_BITS-1:0]                    element_value,
    output logic [1:0]                                extremum_class,
    output logic [lxd_pkg::COUNT_BITS-1:0]            maxima_total,
    output logic [lxd_pkg::COUNT_BITS-1:0]            minima_total,
    output logic                                      frame_end
);

    localparam int SEL_W = $clog2(lxd_pkg::RESULT_SLOTS);

    lxd_pkg::result_meta_t                   meta_reg [lxd_pkg::RESULT_SLOTS];
    logic [SAMPLE_BITS-1:0]                  value_reg [lxd_pkg::RESULT_SLOTS];
    logic [lxd_pkg::RESULT_SLOTS-1:0]        mask_reg;
    logic [lxd_pkg::RESULT_SLOTS-1:0]        mask_next;
    logic [SEL_W-1:0]                        sel;
    logic [lxd_pkg::RESULT_SLOTS-1:0]        sel_onehot;
    logic                                    drain;
    lxd_pkg::result_meta_t                   sel_meta;

    logic [lxd_pkg::COUNT_BITS-1:0]          max_cnt_reg;
    logic [lxd_pkg::COUNT_BITS-1:0]          min_cnt_reg;
    logic [lxd_pkg::COUNT_BITS-1:0]          max_cnt_next;
    logic [lxd_pkg::COUNT_BITS-1:0]          min_cnt_next;
    logic [lxd_pkg::COUNT_BITS-1:0]          max_total;
    logic [lxd_pkg::COUNT_BITS-1:0]          min_total;

    logic                                    out_valid_reg;
    logic [lxd_pkg::ROW_BITS-1:0]            out_row_reg;
    logic [lxd_pkg::COLUMN_BITS-1:0]         out_column_reg;
    logic [SAMPLE_BITS-1:0]                  out_value_reg;
    lxd_pkg::extremum_class_t                out_class_reg;
    logic [lxd_pkg::COUNT_BITS-1:0]          out_max_reg;
    logic [lxd_pkg::COUNT_BITS-1:0]          out_min_reg;
    logic                                    out_last_reg;

    // The lowest pending slot goes out first.
    always_comb
    begin
        sel = '0;
        priority if (mask_reg[0])
        begin
            sel = SEL_W'(0);
        end
        else if (mask_reg[1])
        begin
            sel = SEL_W'(1);
        end
        else if (mask_reg[2])
        begin
            sel = SEL_W'(2);
        end
        else
        begin
            sel = SEL_W'(3);
        end
        sel_onehot = lxd_pkg::RESULT_SLOTS'(1) << sel;
        sel_meta   = meta_reg[sel];
    end

    assign drain = (|mask_reg) && (!out_valid_reg || out_ready);

    // New results fit when every slot is gone by the end of this cycle.
    assign free = (mask_reg == '0) || ($onehot(mask_reg) && drain);

    always_comb
    begin
        priority if (load)
        begin
            mask_next = load_mask;
        end
        else if (drain)
        begin
            mask_next = mask_reg & ~sel_onehot;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    // Saturating counts, including the beat that leaves now.
    always_comb
    begin
        max_total = max_cnt_reg;
        min_total = min_cnt_reg;
        if (sel_meta.ext_class == lxd_pkg::CLASS_MAX && max_cnt_reg != lxd_pkg::COUNT_MAX)
        begin
            max_total = max_cnt_reg + lxd_pkg::COUNT_BITS'(1);
        end
        if (sel_meta.ext_class == lxd_pkg::CLASS_MIN && min_cnt_reg != lxd_pkg::COUNT_MAX)
        begin
            min_total = min_cnt_reg + lxd_pkg::COUNT_BITS'(1);
        end
    end

    // The counts restart after the last beat of a frame and on a restart.
    always_comb
    begin
        priority if (restart)
        begin
            max_cnt_next = '0;
            min_cnt_next = '0;
        end
        else if (drain && sel_meta.last)
        begin
            max_cnt_next = '0;
            min_cnt_next = '0;
        end
        else if (drain)
        begin
            max_cnt_next = max_total;
            min_cnt_next = min_total;
        end
        else
        begin
            max_cnt_next = max_cnt_reg;
            min_cnt_next = min_cnt_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            max_cnt_reg   <= '0;
            min_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg    <= mask_next;
            max_cnt_reg <= max_cnt_next;
            min_cnt_reg <= min_cnt_next;
            if (drain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Slot payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < lxd_pkg::RESULT_SLOTS; i++)
            begin
                meta_reg[i]  <= load_meta[i];
                value_reg[i] <= load_value[i];
            end
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_row_reg    <= sel_meta.row;
            out_column_reg <= sel_meta.column;
            out_value_reg  <= value_reg[sel];
            out_class_reg  <= sel_meta.ext_class;
            out_max_reg    <= max_total;
            out_min_reg    <= min_total;
            out_last_reg   <= sel_meta.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign row_index      = out_row_reg;
    assign column_index   = out_column_reg;
    assign element_value  = out_value_reg;
    assign extremum_class = out_class_reg;
    assign maxima_total   = out_max_reg;
    assign minima_total   = out_min_reg;
    assign frame_end      = out_last_reg;

    // Pending results are never dropped while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((|mask_reg) && out_valid_reg && !out_ready) |=> (mask_reg == $past(mask_reg)))
        else $error("result slots changed during an output stall");

    // The end of a frame clears both counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain && sel_meta.last) |=> (max_cnt_reg == '0 && min_cnt_reg == '0))
        else $error("counts not cleared after the frame end");

    // Only the last slot can carry the frame end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (drain && sel_meta.last) |-> (sel == SEL_W'(3)))
        else $error("frame end taken from a slot other than the last");

endmodule

/* rtl/local_extrema_detector_8_neighbour_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_extrema_detector_8_neighbour_top: streaming 3x3 extrema detector
// Classifies each matrix element as a strict local maximum, minimum or
// neither against its in-bounds 8-neighbors, from a raster sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/sample) takes one raster-order sample
//   per beat. Output channel (out_valid/out_ready/...) gives one classified
//   element per beat, in the order in which neighborhoods complete; the
//   last beat of a frame has frame_end set.
//   Registers row_count and column_count are written through cfg_write,
//   cfg_index and cfg_data while the block is idle; any write restarts the
//   frame (position, counts and window cleared, line contents kept).
//   The first result of a beat that completes its neighborhood is offered
//   after the lookup stage, a result slot and the output register.
//   Throughput: one sample per cycle while out_ready is high. A sample
//   that completes more than one result holds the input while its extra
//   results leave one per cycle: one at each row end after the first row,
//   one per last-row sample but its first, three for a frame's last sample.
//   The two line buffers share one RAM with a registered read; the read at
//   accept and the write-back on advance never meet on one address.
//   Reset clears position, counts, window and all valid flags; the line RAM
//   is not cleared. When the receiver stalls, up to four results wait in the
//   queue and then the input stops taking beats.
// ----------------------------------------------------------------------------
module local_extrema_detector_8_neighbour_top #(
    parameter int MAX_COLUMNS = lxd_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS = lxd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [lxd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [SAMPLE_BITS-1:0]              sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lxd_pkg::ROW_BITS-1:0]        row_index,
    output logic [lxd_pkg::COLUMN_BITS-1:0]     column_index,
    output logic [SAMPLE_BITS-1:0]              element_value,
    output logic [1:0]                          extremum_class,
    output logic [lxd_pkg::COUNT_BITS-1:0]      maxima_total,
    output logic [lxd_pkg::COUNT_BITS-1:0]      minima_total,
    output logic                                frame_end
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int SLOTS  = lxd_pkg::RESULT_SLOTS;
    localparam int RB     = lxd_pkg::ROW_BITS;
    localparam int CB     = lxd_pkg::COLUMN_BITS;

    // Configuration and position.
    logic [RB-1:0]                       row_cfg_reg;
    logic [lxd_pkg::COLUMN_CFG_BITS-1:0] col_cfg_reg;
    logic [RB-1:0]                       eff_rows;
    logic [CNT_W-1:0]                    eff_cols;
    logic [RB-1:0]                       row_reg;
    logic [RB-1:0]                       row_next;
    logic [COL_W-1:0]                    col_reg;
    logic [COL_W-1:0]                    col_next;
    logic                                in_accept;
    logic                                last_col;
    logic                                last_row;

    // Lookup stage: holds the beat while its line data is read.
    logic                                a_valid_reg;
    logic [SAMPLE_BITS-1:0]              a_sample_reg;
    logic [RB-1:0]                       a_row_reg;
    logic [COL_W-1:0]                    a_col_reg;
    logic                                a_last_row_reg;
    logic                                a_last_col_reg;
    logic                                a_advance;
    logic                                q_free;

    // Line RAM: upper line in the high half, middle line in the low half.
    logic [2*SAMPLE_BITS-1:0]            ram_rd_data;
    logic [SAMPLE_BITS-1:0]              rd_upper;
    logic [SAMPLE_BITS-1:0]              rd_middle;

    // 3x3 window: two stored columns plus the column being read.
    logic [SAMPLE_BITS-1:0]              win_reg [6];
    logic [SAMPLE_BITS-1:0]              g [3][3];

    // Classification inputs and results.
    logic [SLOTS-1:0][SAMPLE_BITS-1:0]       cls_center;
    logic [SLOTS-1:0][7:0][SAMPLE_BITS-1:0]  cls_nb;
    logic [SLOTS-1:0][7:0]                   cls_inc;
    lxd_pkg::extremum_class_t                cls_out [SLOTS];
    lxd_pkg::result_meta_t                   res_meta [SLOTS];
    logic [SLOTS-1:0]                        res_mask;
    logic                                    up_ok;
    logic                                    left_ok;
    logic                                    r_ge1;
    logic                                    c_ge1;
    logic [RB-1:0]                           row_m1;
    logic [COL_W-1:0]                        col_m1;

    // Effective frame size: both at least two, columns clamped to the RAM.
    always_comb
    begin
        eff_rows = (row_cfg_reg < RB'(2)) ? RB'(2) : row_cfg_reg;
        if (col_cfg_reg < lxd_pkg::COLUMN_CFG_BITS'(2))
        begin
            eff_cols = CNT_W'(2);
        end
        else if (32'(col_cfg_reg) > MAX_COLUMNS)
        begin
            eff_cols = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = CNT_W'(col_cfg_reg);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg <= RB'(2);
            col_cfg_reg <= lxd_pkg::COLUMN_CFG_BITS'(2);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lxd_pkg::REG_ROW_COUNT:
                begin
                    row_cfg_reg <= cfg_data[RB-1:0];
                end
                lxd_pkg::REG_COLUMN_COUNT:
                begin
                    col_cfg_reg <= cfg_data[lxd_pkg::COLUMN_CFG_BITS-1:0];
                end
                default:
                begin
                    row_cfg_reg <= row_cfg_reg;
                end
            endcase
        end
    end

    // Input handshake and raster position of the next beat.
    assign a_advance = a_valid_reg && q_free;
    assign in_ready  = !a_valid_reg || q_free;
    assign in_accept = in_valid && in_ready;
    assign last_col  = (CNT_W'(col_reg) + CNT_W'(1)) == eff_cols;
    assign last_row  = ({1'b0, row_reg} + (RB+1)'(1)) >= {1'b0, eff_rows};

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        priority if (cfg_write)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (in_accept && last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RB'(1);
        end
        else if (in_accept)
        begin
            col_next = col_reg + COL_W'(1);
        end
        else
        begin
            col_next = col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (in_accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    // Lookup stage payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_sample_reg   <= sample;
            a_row_reg      <= row_reg;
            a_col_reg      <= col_reg;
            a_last_row_reg <= last_row;
            a_last_col_reg <= last_col;
        end
    end

    // Line RAM: read at accept, write the rotated column back on advance.
    lxd_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (a_advance),
        .wr_addr (a_col_reg),
        .wr_data ({rd_middle, a_sample_reg}),
        .rd_en   (in_accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    assign rd_upper  = ram_rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign rd_middle = ram_rd_data[SAMPLE_BITS-1:0];

    // Window assembly: g[row][column], column 2 is the newest.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            g[i][0] = win_reg[i];
            g[i][1] = win_reg[3 + i];
        end
        g[0][2] = rd_upper;
        g[1][2] = rd_middle;
        g[2][2] = a_sample_reg;
    end

    // Window shift on advance; a frame restart clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (a_advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i]     <= g[i][1];
                win_reg[3 + i] <= g[i][2];
            end
        end
    end

    // Boundary flags of the beat in the lookup stage.
    assign r_ge1   = a_row_reg != '0;
    assign c_ge1   = a_col_reg != '0;
    assign up_ok   = a_row_reg > RB'(1);
    assign left_ok = CNT_W'(a_col_reg) > CNT_W'(1);
    assign row_m1  = a_row_reg - RB'(1);
    assign col_m1  = a_col_reg - COL_W'(1);

    // Neighbor sets of the four candidate elements. Neighbor order is
    // up-left, up, up-right, left, right, down-left, down, down-right;
    // unused places carry the center and are masked off.
    always_comb
    begin
        // Element above-left of the new sample.
        cls_center[0] = g[1][1];
        cls_nb[0]     = {g[2][2], g[2][1], g[2][0], g[1][2],
                         g[1][0], g[0][2], g[0][1], g[0][0]};
        cls_inc[0]    = {1'b1, 1'b1, left_ok, 1'b1,
                         left_ok, up_ok, up_ok, up_ok && left_ok};

        // Element above the new sample, last column.
        cls_center[1] = g[1][2];
        cls_nb[1]     = {g[1][2], g[2][2], g[2][1], g[1][2],
                         g[1][1], g[1][2], g[0][2], g[0][1]};
        cls_inc[1]    = {1'b0, 1'b1, 1'b1, 1'b0,
                         1'b1, 1'b0, up_ok, up_ok};

        // Element left of the new sample, last row.
        cls_center[2] = g[2][1];
        cls_nb[2]     = {g[2][1], g[2][1], g[2][1], g[2][2],
                         g[2][0], g[1][2], g[1][1], g[1][0]};
        cls_inc[2]    = {1'b0, 1'b0, 1'b0, 1'b1,
                         left_ok, 1'b1, 1'b1, left_ok};

        // The new sample itself, last row and column.
        cls_center[3] = g[2][2];
        cls_nb[3]     = {g[2][2], g[2][2], g[2][2], g[2][2],
                         g[2][1], g[2][2], g[1][2], g[1][1]};
        cls_inc[3]    = {1'b0, 1'b0, 1'b0, 1'b0,
                         1'b1, 1'b0, 1'b1, 1'b1};
    end

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cls
        lxd_classify #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_classify (
            .center     (cls_center[k]),
            .neighbours (cls_nb[k]),
            .nb_used    (cls_inc[k]),
            .ext_class  (cls_out[k])
        );
    end

    // Which results this beat completes, and where they sit.
    always_comb
    begin
        res_mask[0] = r_ge1 && c_ge1;
        res_mask[1] = r_ge1 && a_last_col_reg;
        res_mask[2] = a_last_row_reg && c_ge1;
        res_mask[3] = a_last_row_reg && a_last_col_reg;

        res_meta[0] = '{row: row_m1, column: CB'(col_m1),
                        ext_class: cls_out[0], last: 1'b0};
        res_meta[1] = '{row: row_m1, column: CB'(a_col_reg),
                        ext_class: cls_out[1], last: 1'b0};
        res_meta[2] = '{row: a_row_reg, column: CB'(col_m1),
                        ext_class: cls_out[2], last: 1'b0};
        res_meta[3] = '{row: a_row_reg, column: CB'(a_col_reg),
                        ext_class: cls_out[3], last: 1'b1};
    end

    lxd_result_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_result_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .restart        (cfg_write),
        .load           (a_advance),
        .load_mask      (res_mask),
        .load_meta      (res_meta),
        .load_value     (cls_center),
        .free           (q_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .row_index      (row_index),
        .column_index   (column_index),
        .element_value  (element_value),
        .extremum_class (extremum_class),
        .maxima_total   (maxima_total),
        .minima_total   (minima_total),
        .frame_end      (frame_end)
    );

    // The RAM read of a new beat never hits the column being written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && a_advance) |-> (col_reg != a_col_reg))
        else $error("line RAM read and write collide on one column");

    // A beat held in the lookup stage keeps its position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !q_free) |=> (a_valid_reg && $stable(a_col_reg)
                                      && $stable(a_row_reg)))
        else $error("lookup stage lost a stalled beat");

    // The column position stays inside the configured frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(col_reg) < eff_cols)
        else $error("column position beyond the frame width");

endmodule
